// ----- src/fab_pkg.sv -----
// Shared types and constants for the frame bitmap allocator.
// Holds the request/result structs, status and command codes, and sizing constants.
// No dependencies.
package fab_pkg;

    // Sizing
    localparam int DEF_MAX_FRAMES    = 4096;
    localparam int WORD_BITS         = 32;
    localparam int FRAME_FIELD_LIMIT = 4096;
    localparam int FRAME_W           = 12;
    localparam int CFG_W             = 13;
    localparam int STATUS_W          = 3;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;

    // Register map (word index taken from paddr[2])
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 13'd4096;

    // Commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_ALLOCATED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ALREADY_ALLOC = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OUT_OF_FRAMES = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FREED         = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTHING_FREE  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_OUT_OF_RANGE  = 3'd5;

    typedef struct packed {
        logic               command;
        logic [FRAME_W-1:0] current_frame;
        logic               kernel_owned;
        logic               writable;
    } request_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_number;
        logic                present_bit;
        logic                rw_bit;
        logic                user_bit;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

// ----- src/frame_bitmap_allocator.sv -----
// Frame bitmap allocator: first-fit page frame allocation over a word bitmap.
// Depends on fab_pkg (request/result types, status codes, sizing constants).
//
//   Channel   Signals                               Transfer
//   --------  ------------------------------------  --------------------------------
//   config    psel penable pwrite paddr pwdata ...  write on psel&penable&pwrite
//   request   start busy request                    taken when start=1 and busy=0
//   result    done result                           one cycle, done=1, no backpressure
//
// An already-allocated or rejected request is answered from the decide state, a free
// after a read there and a write in the free-write state. An allocation scans the bitmap
// one word per cycle through the single memory read port, over up to (clamped frames_in_use)/32 words.
// busy falls in the done cycle, so the next request can be taken there.
// Reset clears the per-word valid flags at once; an unwritten word reads as all free,
// so no clearing pass is needed. Results are never stalled.
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES = fab_pkg::DEF_MAX_FRAMES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fab_pkg::PADDR_W-1:0] paddr,
    input  logic [fab_pkg::PDATA_W-1:0] pwdata,
    output logic [fab_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        start,
    input  fab_pkg::request_t           request,
    output logic                        busy,
    output logic                        done,
    output fab_pkg::result_t            result
);
    import fab_pkg::*;

    localparam int EFF_FRAMES = (MAX_FRAMES < FRAME_FIELD_LIMIT) ? MAX_FRAMES
                                                                 : FRAME_FIELD_LIMIT;
    localparam int WORD_COUNT = EFF_FRAMES / WORD_BITS;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int CNT_W      = $clog2(WORD_COUNT + 1);
    localparam int BIT_W      = $clog2(WORD_BITS);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECIDE  = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_FREE_WR = 3'd3;

    logic [2:0]            state_reg, state_next;
    request_t              req_reg;
    logic [CFG_W-1:0]      cfg_reg;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;
    logic [WORD_COUNT-1:0] valid_reg;

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_valid_reg;

    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [WORD_BITS-1:0]  wr_data;

    logic [CFG_W-1:0]      frame_limit;
    logic [CNT_W-1:0]      words;
    logic [WORD_BITS-1:0]  rd_word;
    logic [WORD_BITS-1:0]  zero_onehot;
    logic [BIT_W-1:0]      zero_pos;
    logic                  hit;
    logic                  cfg_wr;

    // Encode a one-hot word into its bit position
    function automatic logic [BIT_W-1:0] onehot_pos(input logic [WORD_BITS-1:0] oh);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            pos = pos | (oh[i] ? BIT_W'(i) : '0);
        end
        return pos;
    endfunction

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE);
    assign prdata = (paddr[2] == REG_FRAMES_IN_USE)
                    ? PDATA_W'(cfg_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= FRAMES_IN_USE_RST;
        end
        else if (cfg_wr)
        begin
            cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp the managed frame count and derive the whole-word search bound
    assign frame_limit = (cfg_reg > CFG_W'(EFF_FRAMES)) ? CFG_W'(EFF_FRAMES) : cfg_reg;
    assign words       = CNT_W'(frame_limit >> BIT_W);

    // Word as last read; a never-written word is all free
    assign rd_word     = rd_valid_reg ? rd_data_reg : '0;
    assign zero_onehot = ~rd_word & (rd_word + WORD_BITS'(1));
    assign zero_pos    = onehot_pos(zero_onehot);
    assign hit         = pend_reg && (rd_word != '1);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = pend_idx_reg;
        wr_data       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                result_next = '0;
                if (req_reg.command == CMD_ALLOC)
                begin
                    if (req_reg.current_frame != '0)
                    begin
                        result_next.frame_number = req_reg.current_frame;
                        result_next.status       = STAT_ALREADY_ALLOC;
                        done_next                = 1'b1;
                        state_next               = ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
                else if (req_reg.current_frame == '0)
                begin
                    result_next.status = STAT_NOTHING_FREE;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
                else if ({1'b0, req_reg.current_frame} >= frame_limit)
                begin
                    result_next.frame_number = req_reg.current_frame;
                    result_next.status       = STAT_OUT_OF_RANGE;
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_W'(req_reg.current_frame[FRAME_W-1:BIT_W]);
                    state_next = ST_FREE_WR;
                end
            end

            ST_SCAN:
            begin
                // Check the word read last cycle while fetching the next one
                if (hit)
                begin
                    wr_en                    = 1'b1;
                    wr_addr                  = pend_idx_reg;
                    wr_data                  = rd_word | zero_onehot;
                    result_next              = '0;
                    result_next.frame_number = FRAME_W'({pend_idx_reg, zero_pos});
                    result_next.present_bit  = 1'b1;
                    result_next.rw_bit       = req_reg.writable;
                    result_next.user_bit     = ~req_reg.kernel_owned;
                    result_next.status       = STAT_ALLOCATED;
                    done_next                = 1'b1;
                    state_next               = ST_IDLE;
                end
                else if (scan_idx_reg < words)
                begin
                    rd_en         = 1'b1;
                    rd_addr       = scan_idx_reg[ADDR_W-1:0];
                    pend_next     = 1'b1;
                    pend_idx_next = scan_idx_reg[ADDR_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    result_next        = '0;
                    result_next.status = STAT_OUT_OF_FRAMES;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
            end

            ST_FREE_WR:
            begin
                // Clear the frame's bit in the word just read
                wr_en              = 1'b1;
                wr_addr            = ADDR_W'(req_reg.current_frame[FRAME_W-1:BIT_W]);
                wr_data            = rd_word
                                   & ~(WORD_BITS'(1) << req_reg.current_frame[BIT_W-1:0]);
                result_next        = '0;
                result_next.status = STAT_FREED;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
            done_reg     <= 1'b0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            pend_reg     <= pend_next;
            done_reg     <= done_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Payload registers: hold the request, the pending word index and the result
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg <= request;
        end
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    // Bitmap memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- src/fab_checker.sv -----
// Port-level checks for the frame bitmap allocator, attached by bind.
// Depends on fab_pkg (result type, status codes) and frame_bitmap_allocator.
module fab_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input fab_pkg::result_t            result
);
    import fab_pkg::*;

    // An accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A result only follows work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // One result per request: strobes never come back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // Entry flags are set only on a successful allocation
    a_flags_alloc_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STAT_ALLOCATED) |->
            (!result.present_bit && !result.rw_bit && !result.user_bit))
        else $error("entry flags set on a result other than an allocation");

    // A freed, empty or failed-allocation entry reports frame zero
    a_free_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == STAT_FREED || result.status == STAT_NOTHING_FREE
                  || result.status == STAT_OUT_OF_FRAMES)) |->
            (result.frame_number == '0))
        else $error("nonzero frame reported after a free or failed allocation");

endmodule

bind frame_bitmap_allocator fab_checker u_fab_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .result  (result)
);

// ----- tb/tb_frame_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for frame_bitmap_allocator: directed table, then random phases.
// Depends on fab_pkg for the request/result structs, command and status codes, and sizes.
module tb_frame_bitmap_allocator;
    import fab_pkg::*;

    localparam int MAP_WORDS    = DEF_MAX_FRAMES / WORD_BITS;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 140;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASE_COUNT  = 10;
    localparam int DIRECT_ROWS  = 24;
    localparam logic [PADDR_W-1:0] FRAMES_IN_USE_ADDR = {REG_FRAMES_IN_USE, 2'b00};

    typedef struct {
        bit               is_config;
        logic [CFG_W-1:0] config_value;
        request_t         req;
        bit               typed;
        result_t          want;
    } directed_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start = 1'b0;
    request_t           request = '0;
    logic               busy;
    logic               done;
    result_t            result;

    // Allocator mirror: bitmap, managed frame count, outstanding results, frames handed out
    logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
    logic [CFG_W-1:0]     managed_frames;
    result_t              pending_results [$];
    logic [FRAME_W-1:0]   held_frames [$];
    int                   error_count = 0;
    int                   quiet_cycles = 0;

    directed_row_t        directed_rows [DIRECT_ROWS];
    logic [CFG_W-1:0]     phase_frames [PHASE_COUNT] =
        '{13'd4096, 13'd32, 13'd64, 13'd33, 13'd0, 13'd8191, 13'd100, 13'd4095, 13'd4064, 13'd32};

    frame_bitmap_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Frame limit in effect: register value held to the bitmap size and the frame field range
    function automatic int usable_frames();
        int lim;
        lim = int'(managed_frames);
        if (lim > DEF_MAX_FRAMES) lim = DEF_MAX_FRAMES;
        if (lim > FRAME_FIELD_LIMIT) lim = FRAME_FIELD_LIMIT;
        return lim;
    endfunction

    // Apply one request to the mirrored bitmap and return the result the block should give
    function automatic result_t predict_frame_op(request_t r);
        result_t res;
        int      lim;
        int      w;
        int      b;
        bit      found;
        res   = '0;
        lim   = usable_frames();
        found = 1'b0;
        if (r.command == CMD_ALLOC) begin
            if (r.current_frame != 0) begin
                res.frame_number = r.current_frame;
                res.status       = STAT_ALREADY_ALLOC;
            end
            else begin
                // first fit over whole words below the limit
                for (w = 0; w < lim / WORD_BITS && !found; w++) begin
                    for (b = 0; b < WORD_BITS && !found; b++) begin
                        if (!frame_map[w][b]) begin
                            found            = 1'b1;
                            frame_map[w][b]  = 1'b1;
                            res.frame_number = FRAME_W'(w * WORD_BITS + b);
                        end
                    end
                end
                if (found) begin
                    res.present_bit = 1'b1;
                    res.rw_bit      = r.writable;
                    res.user_bit    = ~r.kernel_owned;
                    res.status      = STAT_ALLOCATED;
                end
                else begin
                    res.status = STAT_OUT_OF_FRAMES;
                end
            end
        end
        else begin
            if (r.current_frame == 0) begin
                res.status = STAT_NOTHING_FREE;
            end
            else if (int'(r.current_frame) >= lim) begin
                res.frame_number = r.current_frame;
                res.status       = STAT_OUT_OF_RANGE;
            end
            else begin
                frame_map[r.current_frame / WORD_BITS][r.current_frame % WORD_BITS] = 1'b0;
                res.status = STAT_FREED;
            end
        end
        return res;
    endfunction

    function automatic request_t make_request(logic cmd, logic [FRAME_W-1:0] cur,
                                              logic kern, logic wr);
        request_t r;
        r.command       = cmd;
        r.current_frame = cur;
        r.kernel_owned  = kern;
        r.writable      = wr;
        return r;
    endfunction

    function automatic directed_row_t req_row(logic cmd, logic [FRAME_W-1:0] cur,
                                              logic kern, logic wr);
        directed_row_t row;
        row.is_config    = 1'b0;
        row.config_value = '0;
        row.req          = make_request(cmd, cur, kern, wr);
        row.typed        = 1'b0;
        row.want         = '0;
        return row;
    endfunction

    function automatic directed_row_t typed_row(logic cmd, logic [FRAME_W-1:0] cur,
                                                logic kern, logic wr,
                                                logic [FRAME_W-1:0] frame, logic present,
                                                logic rw, logic user,
                                                logic [STATUS_W-1:0] st);
        directed_row_t row;
        row                   = req_row(cmd, cur, kern, wr);
        row.typed             = 1'b1;
        row.want.frame_number = frame;
        row.want.present_bit  = present;
        row.want.rw_bit       = rw;
        row.want.user_bit     = user;
        row.want.status       = st;
        return row;
    endfunction

    function automatic directed_row_t cfg_row(logic [CFG_W-1:0] value);
        directed_row_t row;
        row              = req_row(CMD_ALLOC, '0, 1'b0, 1'b0);
        row.is_config    = 1'b1;
        row.config_value = value;
        return row;
    endfunction

    // Mostly well-formed traffic: allocations and frees of held frames, plus noise
    function automatic request_t random_request();
        request_t r;
        int       pick;
        int       lim;
        int       idx;
        r              = '0;
        r.kernel_owned = 1'($urandom_range(0, 1));
        r.writable     = 1'($urandom_range(0, 1));
        pick           = $urandom_range(0, 99);
        lim            = usable_frames();
        if (pick < 50) begin
            r.command = CMD_ALLOC;
        end
        else if (pick < 62) begin
            r.command       = CMD_ALLOC;
            r.current_frame = FRAME_W'($urandom_range(0, 4095));
        end
        else begin
            r.command = CMD_FREE;
            if (pick < 82 && held_frames.size() != 0) begin
                idx             = $urandom_range(0, held_frames.size() - 1);
                r.current_frame = held_frames[idx];
                held_frames.delete(idx);
            end
            else if (pick < 87) begin
                r.current_frame = '0;
            end
            else if (pick < 94 || lim > 4095) begin
                r.current_frame = FRAME_W'($urandom_range(0, 4095));
            end
            else begin
                r.current_frame = FRAME_W'($urandom_range(lim, 4095));
            end
        end
        return r;
    endfunction

    // Present one request and hold it until taken; predict at the accepting edge
    task automatic send_request(request_t r, bit typed, result_t want);
        result_t predicted;
        start   <= 1'b1;
        request <= r;
        do @(posedge clk); while (busy);
        predicted = predict_frame_op(r);
        if (predicted.status == STAT_ALLOCATED) held_frames.push_back(predicted.frame_number);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic pause_requests(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop start and wait until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0 || busy);
    endtask

    // Write the frame count register, then read it back
    task automatic write_frames_in_use(logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FRAMES_IN_USE_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        managed_frames = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== PDATA_W'(value)) begin
            error_count++;
            $error("frames_in_use: expected %0d, got %0d", value, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // Compare each result against the oldest outstanding expectation
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $error("result with none outstanding: frame_number %0d status %0d",
                       result.frame_number, result.status);
            end
            else begin
                want = pending_results.pop_front();
                check_field("frame_number", 32'(want.frame_number), 32'(result.frame_number));
                check_field("present_bit", 32'(want.present_bit), 32'(result.present_bit));
                check_field("rw_bit", 32'(want.rw_bit), 32'(result.rw_bit));
                check_field("user_bit", 32'(want.user_bit), 32'(result.user_bit));
                check_field("status", 32'(want.status), 32'(result.status));
            end
        end
    end

    // Abort when nothing moves on any port for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int               p;
        int               i;
        bit               calm;
        logic [CFG_W-1:0] value;

        foreach (frame_map[k]) frame_map[k] = '0;
        managed_frames = FRAMES_IN_USE_RST;

        directed_rows = '{
            typed_row(CMD_ALLOC, 12'd0, 1'b0, 1'b1, 12'd0, 1'b1, 1'b1, 1'b1, STAT_ALLOCATED),
            typed_row(CMD_ALLOC, 12'd0, 1'b1, 1'b0, 12'd1, 1'b1, 1'b0, 1'b0, STAT_ALLOCATED),
            typed_row(CMD_ALLOC, 12'd4095, 1'b1, 1'b1, 12'd4095, 1'b0, 1'b0, 1'b0,
                      STAT_ALREADY_ALLOC),
            typed_row(CMD_FREE, 12'd0, 1'b1, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0, STAT_NOTHING_FREE),
            typed_row(CMD_FREE, 12'd1, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0, STAT_FREED),
            typed_row(CMD_FREE, 12'd4095, 1'b1, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0, STAT_FREED),
            req_row(CMD_ALLOC, 12'd0, 1'b0, 1'b0),
            cfg_row(13'd0),
            typed_row(CMD_ALLOC, 12'd0, 1'b1, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0,
                      STAT_OUT_OF_FRAMES),
            typed_row(CMD_FREE, 12'd1, 1'b0, 1'b1, 12'd1, 1'b0, 1'b0, 1'b0, STAT_OUT_OF_RANGE),
            typed_row(CMD_FREE, 12'd4095, 1'b0, 1'b0, 12'd4095, 1'b0, 1'b0, 1'b0,
                      STAT_OUT_OF_RANGE),
            cfg_row(13'd33),
            req_row(CMD_ALLOC, 12'd0, 1'b1, 1'b1),
            typed_row(CMD_FREE, 12'd32, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0, STAT_FREED),
            typed_row(CMD_FREE, 12'd33, 1'b0, 1'b0, 12'd33, 1'b0, 1'b0, 1'b0,
                      STAT_OUT_OF_RANGE),
            cfg_row(13'd8191),
            typed_row(CMD_FREE, 12'd4095, 1'b0, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0, STAT_FREED),
            req_row(CMD_ALLOC, 12'd0, 1'b0, 1'b1),
            cfg_row(13'd4096),
            typed_row(CMD_FREE, 12'd2, 1'b1, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0, STAT_FREED),
            req_row(CMD_ALLOC, 12'd0, 1'b0, 1'b1),
            cfg_row(13'd32),
            req_row(CMD_ALLOC, 12'd0, 1'b1, 1'b0),
            typed_row(CMD_FREE, 12'd31, 1'b0, 1'b0, 12'd0, 1'b0, 1'b0, 1'b0, STAT_FREED)
        };

        // Hold reset, then release on a clock edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_config) begin
                drain_results();
                write_frames_in_use(directed_rows[r].config_value);
            end
            else begin
                send_request(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want);
                if ($urandom_range(0, 2) == 0) pause_requests($urandom_range(1, 14));
            end
        end

        // Random phases, each under its own frame count; no gaps in the last one
        for (p = 0; p < PHASE_COUNT; p++) begin
            value = (p == 8) ? CFG_W'($urandom_range(0, 8191)) : phase_frames[p];
            drain_results();
            write_frames_in_use(value);
            calm = ($urandom_range(0, 3) == 0) || (p == PHASE_COUNT - 1);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_request(random_request(), 1'b0, '0);
                if (!calm && $urandom_range(0, 3) == 0) pause_requests($urandom_range(1, 14));
            end
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
